### hw/rtl/tfcr_pkg.sv
// shared types and constants for the throttle filter and current ramp block
package tfcr_pkg;

    localparam int unsigned DataW   = 16;
    localparam int unsigned AccW    = 32;
    localparam int unsigned StepW   = 15;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CntW    = 4;

    localparam logic [DataW-1:0] FailedSample = 16'hFFFF;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] RegSensorVirtual    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegExpectedThrottle = 3'd1;
    localparam logic [CfgIdxW-1:0] RegFilterBandwidth  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegTargetSlope      = 3'd3;
    localparam logic [CfgIdxW-1:0] RegThrottleOffset   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegRampStep         = 3'd5;

    // reset values of the configuration registers
    localparam logic [DataW-1:0] RstFilterBandwidth = 16'd16;
    localparam logic [DataW-1:0] RstTargetSlope     = 16'd1;
    localparam logic [StepW-1:0] RstRampStep        = 15'd1;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_mdu_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        t_mdu_op          op;
        logic [AccW-1:0]  opa;
        logic [DataW-1:0] opb;
        logic [DataW-1:0] addend;
    } t_mdu_req;

    typedef struct packed {
        logic            done;
        logic [AccW-1:0] result;
    } t_mdu_rsp;

endpackage

### hw/rtl/tfcr_mdu.sv
// iterative shift-add multiplier and restoring divider sharing one adder
module tfcr_mdu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tfcr_pkg::t_mdu_req  i_req,
    output tfcr_pkg::t_mdu_rsp  o_rsp
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [tfcr_pkg::CntW-1:0]     r_cnt, n_cnt;
    tfcr_pkg::t_mdu_op             r_op, n_op;
    logic [tfcr_pkg::AccW-1:0]     r_acc, n_acc;
    logic [tfcr_pkg::AccW-1:0]     r_sh, n_sh;
    logic [tfcr_pkg::DataW-1:0]    r_opb, n_opb;

    logic [tfcr_pkg::AccW-1:0]     w_x, w_y;
    logic                          w_cin;
    logic [tfcr_pkg::AccW:0]       w_sum;
    logic [tfcr_pkg::DataW:0]      w_trial;
    logic                          w_ge;

    // trial remainder: old remainder shifted with the next dividend bit
    assign w_trial = {r_acc[tfcr_pkg::DataW-1:0], r_sh[tfcr_pkg::DataW-1]};

    // the one shared adder
    always_comb begin
        if (r_op == tfcr_pkg::OP_MUL) begin
            w_x   = r_acc;
            w_y   = r_opb[0] ? r_sh : '0;
            w_cin = 1'b0;
        end else begin
            w_x   = {{(tfcr_pkg::AccW-tfcr_pkg::DataW-1){1'b0}}, w_trial};
            w_y   = ~{{(tfcr_pkg::AccW-tfcr_pkg::DataW){1'b0}}, r_opb};
            w_cin = 1'b1;
        end
        w_sum = {1'b0, w_x} + {1'b0, w_y} + {{tfcr_pkg::AccW{1'b0}}, w_cin};
    end

    assign w_ge = w_sum[tfcr_pkg::AccW];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_acc  = r_acc;
        n_sh   = r_sh;
        n_opb  = r_opb;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_op   = i_req.op;
            n_opb  = i_req.opb;
            if (i_req.op == tfcr_pkg::OP_MUL) begin
                n_acc = {{(tfcr_pkg::AccW-tfcr_pkg::DataW){1'b0}}, i_req.addend};
                n_sh  = i_req.opa;
            end else begin
                n_acc = {{(tfcr_pkg::AccW-tfcr_pkg::DataW){1'b0}},
                         i_req.opa[tfcr_pkg::AccW-1:tfcr_pkg::DataW]};
                n_sh  = {{(tfcr_pkg::AccW-tfcr_pkg::DataW){1'b0}},
                         i_req.opa[tfcr_pkg::DataW-1:0]};
            end
        end else if (r_busy) begin
            if (r_op == tfcr_pkg::OP_MUL) begin
                n_acc = w_sum[tfcr_pkg::AccW-1:0];
                n_sh  = {r_sh[tfcr_pkg::AccW-2:0], 1'b0};
                n_opb = {1'b0, r_opb[tfcr_pkg::DataW-1:1]};
            end else begin
                // remainder stays below the divisor, so 16 bits hold it
                n_acc = {{(tfcr_pkg::AccW-tfcr_pkg::DataW){1'b0}},
                         w_ge ? w_sum[tfcr_pkg::DataW-1:0] : w_trial[tfcr_pkg::DataW-1:0]};
                n_sh  = {r_sh[tfcr_pkg::AccW-2:0], w_ge};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == {tfcr_pkg::CntW{1'b1}}) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= tfcr_pkg::OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_opb <= n_opb;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == tfcr_pkg::OP_MUL) ? r_acc :
                          {{(tfcr_pkg::AccW-tfcr_pkg::DataW){1'b0}},
                           r_sh[tfcr_pkg::DataW-1:0]};

endmodule

### hw/rtl/throttle_filter_current_ramp_top.sv
// throttle averaging filter and ramped current reference, top level
// Usage: the input channel (i_in_valid / o_in_ready) carries one transaction
// per item: i_kind 0 is a throttle ADC sample in i_adc_sample, i_kind 1 asks
// for a new current reference. Every item gives exactly one result on the
// output channel (o_out_valid / i_out_ready): the average after the item and
// the current reference after the item.
// A sample goes through a multiply and then a divide on the one shared
// iterative unit before its result is loaded into the output register; a
// request needs only the multiply; an ignored sample (failed conversion or
// virtual mode) skips the unit. One item is in work at a time: the next is
// accepted only after the last has gone to the output register.
// The configuration port writes a register when i_cfg_we is high; write
// only while no transaction is in flight.
// Reset (synchronous, active low) clears average and reference to zero and
// loads register defaults: bandwidth 16, slope 1, ramp step 1.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and computed, and waits in its final state until the
// output register is free.
module throttle_filter_current_ramp_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic [tfcr_pkg::DataW-1:0]           i_adc_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tfcr_pkg::DataW-1:0]           o_average_throttle,
    output logic signed [tfcr_pkg::DataW-1:0]    o_current_reference,
    input  logic                                 i_cfg_we,
    input  logic [tfcr_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [tfcr_pkg::DataW-1:0]           i_cfg_data
);

    // configuration registers
    logic                          r_virtual;
    logic [tfcr_pkg::DataW-1:0]    r_expected;
    logic [tfcr_pkg::DataW-1:0]    r_bandwidth;
    logic [tfcr_pkg::DataW-1:0]    r_slope;
    logic [tfcr_pkg::DataW-1:0]    r_offset;
    logic [tfcr_pkg::StepW-1:0]    r_step;

    tfcr_pkg::t_state              r_state, n_state;
    logic [tfcr_pkg::DataW-1:0]    r_level, n_level;
    logic [tfcr_pkg::DataW-1:0]    r_ref, n_ref;
    logic                          r_is_req, n_is_req;
    logic                          r_out_valid, n_out_valid;
    logic [tfcr_pkg::DataW-1:0]    r_out_avg, n_out_avg;
    logic [tfcr_pkg::DataW-1:0]    r_out_ref, n_out_ref;

    tfcr_pkg::t_mdu_req            w_req;
    tfcr_pkg::t_mdu_rsp            w_rsp;

    logic                          w_in_accept;
    logic [tfcr_pkg::DataW-1:0]    w_avg0;
    logic [tfcr_pkg::DataW-1:0]    w_bw_eff;
    logic [tfcr_pkg::DataW-1:0]    w_tbits;
    logic [tfcr_pkg::DataW-1:0]    w_step_ext;
    logic                          w_out_free;

    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_avg0      = r_virtual ? r_expected : r_level;
    assign w_bw_eff    = (r_bandwidth == '0) ? {{(tfcr_pkg::DataW-1){1'b0}}, 1'b1}
                                             : r_bandwidth;
    assign w_tbits     = w_rsp.result[tfcr_pkg::DataW-1:0];
    assign w_step_ext  = {1'b0, r_step};
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_virtual   <= 1'b0;
            r_expected  <= '0;
            r_bandwidth <= tfcr_pkg::RstFilterBandwidth;
            r_slope     <= tfcr_pkg::RstTargetSlope;
            r_offset    <= '0;
            r_step      <= tfcr_pkg::RstRampStep;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfcr_pkg::RegSensorVirtual:    r_virtual   <= i_cfg_data[0];
                tfcr_pkg::RegExpectedThrottle: r_expected  <= i_cfg_data;
                tfcr_pkg::RegFilterBandwidth:  r_bandwidth <= i_cfg_data;
                tfcr_pkg::RegTargetSlope:      r_slope     <= i_cfg_data;
                tfcr_pkg::RegThrottleOffset:   r_offset    <= i_cfg_data;
                tfcr_pkg::RegRampStep:         r_step      <= i_cfg_data[tfcr_pkg::StepW-1:0];
                default: ;
            endcase
        end
    end

    tfcr_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_ref       = r_ref;
        n_is_req    = r_is_req;
        n_out_valid = r_out_valid;
        n_out_avg   = r_out_avg;
        n_out_ref   = r_out_ref;
        w_req       = '0;
        w_req.op    = tfcr_pkg::OP_MUL;
        o_in_ready  = (r_state == tfcr_pkg::S_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tfcr_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    // virtual mode loads the average before anything else
                    n_level = w_avg0;
                    if (i_kind) begin
                        w_req.start  = 1'b1;
                        w_req.op     = tfcr_pkg::OP_MUL;
                        w_req.opa    = {{(tfcr_pkg::AccW-tfcr_pkg::DataW){1'b0}},
                                        w_avg0 - r_offset};
                        w_req.opb    = r_slope;
                        w_req.addend = '0;
                        n_is_req     = 1'b1;
                        n_state      = tfcr_pkg::S_MUL;
                    end else if (!r_virtual && i_adc_sample != tfcr_pkg::FailedSample) begin
                        // (bw-1)*avg + sample
                        w_req.start  = 1'b1;
                        w_req.op     = tfcr_pkg::OP_MUL;
                        w_req.opa    = {{(tfcr_pkg::AccW-tfcr_pkg::DataW){1'b0}}, w_avg0};
                        w_req.opb    = w_bw_eff - 1'b1;
                        w_req.addend = i_adc_sample;
                        n_is_req     = 1'b0;
                        n_state      = tfcr_pkg::S_MUL;
                    end else begin
                        n_state = tfcr_pkg::S_DONE;
                    end
                end
            end
            tfcr_pkg::S_MUL: begin
                if (w_rsp.done) begin
                    if (r_is_req) begin
                        // ramp toward a target that lies further out on its side
                        if (!w_tbits[tfcr_pkg::DataW-1]) begin
                            if ($signed(w_tbits) > $signed(r_ref)) begin
                                n_ref = r_ref + w_step_ext;
                            end else begin
                                n_ref = w_tbits;
                            end
                        end else begin
                            if ($signed(w_tbits) < $signed(r_ref)) begin
                                n_ref = r_ref - w_step_ext;
                            end else begin
                                n_ref = w_tbits;
                            end
                        end
                        n_state = tfcr_pkg::S_DONE;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.op    = tfcr_pkg::OP_DIV;
                        w_req.opa   = w_rsp.result;
                        w_req.opb   = w_bw_eff;
                        n_state     = tfcr_pkg::S_DIV;
                    end
                end
            end
            tfcr_pkg::S_DIV: begin
                if (w_rsp.done) begin
                    n_level = w_tbits;
                    n_state = tfcr_pkg::S_DONE;
                end
            end
            tfcr_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_level;
                    n_out_ref   = r_ref;
                    n_state     = tfcr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tfcr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfcr_pkg::S_IDLE;
            r_level     <= '0;
            r_ref       <= '0;
            r_is_req    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_ref       <= n_ref;
            r_is_req    <= n_is_req;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_avg <= n_out_avg;
        r_out_ref <= n_out_ref;
    end

    assign o_out_valid         = r_out_valid;
    assign o_average_throttle  = r_out_avg;
    assign o_current_reference = r_out_ref;

    // the shared unit only finishes while the sequencer waits for it
    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == tfcr_pkg::S_MUL || r_state == tfcr_pkg::S_DIV))
        else $error("arithmetic unit finished outside a wait state");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_state != tfcr_pkg::S_IDLE)
        else $error("accepted transaction did not start work");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tfcr_pkg::S_DONE && w_out_free) |=> o_out_valid)
        else $error("finished result not presented");

    a_virtual_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && r_virtual) |=> r_level == $past(r_expected))
        else $error("virtual mode did not load expected throttle");

endmodule

### tb/throttle_filter_current_ramp_top_test.sv
// testbench for the throttle filter and current ramp block: directed, stall and random traffic
`timescale 1ns / 1ps

module throttle_filter_current_ramp_top_test;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_CYCLES  = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 136;

    typedef struct packed {
        logic [tfcr_pkg::DataW-1:0]        average;
        logic signed [tfcr_pkg::DataW-1:0] reference;
    } t_throttle_out;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic                               i_kind = 1'b0;
    logic [tfcr_pkg::DataW-1:0]         i_adc_sample = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic [tfcr_pkg::DataW-1:0]         o_average_throttle;
    logic signed [tfcr_pkg::DataW-1:0]  o_current_reference;
    logic                               i_cfg_we = 1'b0;
    logic [tfcr_pkg::CfgIdxW-1:0]       i_cfg_index = '0;
    logic [tfcr_pkg::DataW-1:0]         i_cfg_data = '0;

    // register mirror and block state as the testbench sees them
    logic                               cfg_virtual;
    logic [tfcr_pkg::DataW-1:0]         cfg_expected;
    logic [tfcr_pkg::DataW-1:0]         cfg_bandwidth;
    logic [tfcr_pkg::DataW-1:0]         cfg_slope;
    logic [tfcr_pkg::DataW-1:0]         cfg_offset;
    logic [tfcr_pkg::StepW-1:0]         cfg_step;
    logic [tfcr_pkg::DataW-1:0]         flt_level;
    logic [tfcr_pkg::DataW-1:0]         ramp_ref;

    t_throttle_out            awaited_outputs[$];
    int                       mismatch_count = 0;
    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    int                       stall_request = 0;
    int                       stall_granted = 0;
    int                       stall_left = 0;

    throttle_filter_current_ramp_top u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_kind              (i_kind),
        .i_adc_sample        (i_adc_sample),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_average_throttle  (o_average_throttle),
        .o_current_reference (o_current_reference),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_throttle_out advance_filter_ramp(
        input logic kind, input logic [tfcr_pkg::DataW-1:0] sample);
        logic [31:0]                       bw;
        logic [31:0]                       acc;
        logic [31:0]                       quot;
        logic [31:0]                       diff;
        logic [31:0]                       prod;
        logic [tfcr_pkg::DataW-1:0]        tbits;
        logic signed [tfcr_pkg::DataW-1:0] tgt;
        logic signed [tfcr_pkg::DataW-1:0] cur;
        t_throttle_out                     res;
        if (cfg_virtual) begin
            flt_level = cfg_expected;
        end
        if (kind == KIND_SAMPLE) begin
            if (!cfg_virtual && sample != tfcr_pkg::FailedSample) begin
                bw   = (cfg_bandwidth == '0) ? 32'd1 : {16'd0, cfg_bandwidth};
                acc  = (bw - 32'd1) * {16'd0, flt_level} + {16'd0, sample};
                quot = acc / bw;
                flt_level = quot[tfcr_pkg::DataW-1:0];
            end
        end else begin
            // only the low 16 bits of the product matter, wrap is fine
            diff  = {16'd0, flt_level} - {16'd0, cfg_offset};
            prod  = {{16{cfg_slope[tfcr_pkg::DataW-1]}}, cfg_slope} * diff;
            tbits = prod[tfcr_pkg::DataW-1:0];
            tgt   = $signed(tbits);
            cur   = $signed(ramp_ref);
            if (!tgt[tfcr_pkg::DataW-1]) begin
                ramp_ref = (tgt > cur) ? ramp_ref + {1'b0, cfg_step} : tbits;
            end else begin
                ramp_ref = (tgt < cur) ? ramp_ref - {1'b0, cfg_step} : tbits;
            end
        end
        res.average   = flt_level;
        res.reference = $signed(ramp_ref);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [tfcr_pkg::DataW-1:0] got,
                                   input logic [tfcr_pkg::DataW-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("ERROR: %s: got %h expected %h at %0t", what, got, want, $time);
        end
    endtask

    // result checking
    always @(posedge i_clk) begin : check_results
        t_throttle_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_outputs.size() == 0) begin
                report_mismatch("result with no transaction pending", o_average_throttle, '0);
            end else begin
                want = awaited_outputs.pop_front();
                if (o_average_throttle !== want.average) begin
                    report_mismatch("average_throttle", o_average_throttle, want.average);
                end
                if (o_current_reference !== want.reference) begin
                    report_mismatch("current_reference", o_current_reference, want.reference);
                end
            end
        end
    end

    // receiver ready, including the long hold-off counted in cycles
    always @(posedge i_clk) begin : drive_receiver
        if (stall_request != stall_granted) begin
            stall_granted = stall_request;
            stall_left    = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // called at a clock edge; returns at the edge where the transaction is taken
    task automatic send_item(input logic kind, input logic [tfcr_pkg::DataW-1:0] sample);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_adc_sample <= sample;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_outputs.push_back(advance_filter_ramp(kind, sample));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (awaited_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only while nothing is in flight
    task automatic write_register(input logic [tfcr_pkg::CfgIdxW-1:0] idx,
                                  input logic [tfcr_pkg::DataW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            tfcr_pkg::RegSensorVirtual:    cfg_virtual   = value[0];
            tfcr_pkg::RegExpectedThrottle: cfg_expected  = value;
            tfcr_pkg::RegFilterBandwidth:  cfg_bandwidth = value;
            tfcr_pkg::RegTargetSlope:      cfg_slope     = value;
            tfcr_pkg::RegThrottleOffset:   cfg_offset    = value;
            tfcr_pkg::RegRampStep:         cfg_step      = value[tfcr_pkg::StepW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_idling(input int phase);
        case (phase % 3)
            0: begin send_idle_pct = 25; recv_idle_pct = 74; end
            1: begin send_idle_pct = 74; recv_idle_pct = 25; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    task automatic load_random_setting();
        logic [tfcr_pkg::DataW-1:0] bw;
        logic [tfcr_pkg::DataW-1:0] slope;
        logic [tfcr_pkg::DataW-1:0] offs;
        logic [tfcr_pkg::DataW-1:0] step;
        case ($urandom_range(0, 3))
            0: bw = 16'($urandom_range(1, 8));
            1: bw = 16'($urandom_range(9, 300));
            2: bw = 16'($urandom_range(0, 65535));
            default: bw = '0;
        endcase
        if ($urandom_range(0, 1)) begin
            slope = 16'($urandom_range(0, 65535));
        end else begin
            slope = $urandom_range(0, 1) ? 16'($urandom_range(0, 8))
                                         : 16'(-$urandom_range(1, 8));
        end
        offs = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                    : 16'($urandom_range(0, 4096));
        step = $urandom_range(0, 1) ? 16'($urandom_range(0, 32767))
                                    : 16'($urandom_range(1, 200));
        write_register(tfcr_pkg::RegSensorVirtual,
                       ($urandom_range(0, 4) == 0) ? 16'd1 : 16'd0);
        write_register(tfcr_pkg::RegExpectedThrottle, 16'($urandom_range(0, 65535)));
        write_register(tfcr_pkg::RegFilterBandwidth, bw);
        write_register(tfcr_pkg::RegTargetSlope, slope);
        write_register(tfcr_pkg::RegThrottleOffset, offs);
        write_register(tfcr_pkg::RegRampStep, step);
    endtask

    task automatic restore_defaults();
        wait_for_results();
        write_register(tfcr_pkg::RegSensorVirtual, 16'd0);
        write_register(tfcr_pkg::RegFilterBandwidth, tfcr_pkg::RstFilterBandwidth);
        write_register(tfcr_pkg::RegTargetSlope, tfcr_pkg::RstTargetSlope);
        write_register(tfcr_pkg::RegThrottleOffset, 16'd0);
        write_register(tfcr_pkg::RegRampStep, {1'b0, tfcr_pkg::RstRampStep});
    endtask

    // failed conversion, bandwidth extremes including zero
    task automatic test_filter_extremes();
        send_item(KIND_SAMPLE, 16'h0000);
        send_item(KIND_SAMPLE, 16'hFFFE);
        send_item(KIND_SAMPLE, tfcr_pkg::FailedSample);
        send_item(KIND_REQUEST, 16'hFFFF);
        send_item(KIND_REQUEST, 16'h0000);
        wait_for_results();
        write_register(tfcr_pkg::RegFilterBandwidth, 16'd0);
        send_item(KIND_SAMPLE, 16'h8000);
        wait_for_results();
        write_register(tfcr_pkg::RegFilterBandwidth, 16'd1);
        send_item(KIND_SAMPLE, 16'h7FFF);
        send_item(KIND_SAMPLE, 16'hFFFE);
        wait_for_results();
        write_register(tfcr_pkg::RegFilterBandwidth, 16'hFFFF);
        send_item(KIND_SAMPLE, 16'h0000);
        send_item(KIND_SAMPLE, 16'hFFFE);
    endtask

    // gain and step extremes, ramp overshoot and 16-bit wrap
    task automatic test_ramp_extremes();
        wait_for_results();
        write_register(tfcr_pkg::RegThrottleOffset, 16'hFFFF);
        write_register(tfcr_pkg::RegTargetSlope, 16'h7FFF);
        write_register(tfcr_pkg::RegRampStep, 16'h7FFF);
        send_item(KIND_REQUEST, 16'h1234);
        send_item(KIND_REQUEST, 16'hEDCB);
        wait_for_results();
        write_register(tfcr_pkg::RegTargetSlope, 16'h8000);
        write_register(tfcr_pkg::RegThrottleOffset, 16'h0000);
        send_item(KIND_REQUEST, 16'h0000);
        send_item(KIND_REQUEST, 16'hFFFF);
        send_item(KIND_REQUEST, 16'h5555);
        wait_for_results();
        write_register(tfcr_pkg::RegRampStep, 16'h0000);
        send_item(KIND_REQUEST, 16'hAAAA);
    endtask

    // virtual mode overrides the average; real mode then filters from it
    task automatic test_virtual_mode();
        wait_for_results();
        write_register(tfcr_pkg::RegTargetSlope, 16'd3);
        write_register(tfcr_pkg::RegRampStep, 16'd100);
        write_register(tfcr_pkg::RegExpectedThrottle, 16'h1234);
        write_register(tfcr_pkg::RegSensorVirtual, 16'd1);
        send_item(KIND_SAMPLE, 16'h0000);
        send_item(KIND_REQUEST, 16'h0000);
        wait_for_results();
        write_register(tfcr_pkg::RegSensorVirtual, 16'd0);
        send_item(KIND_SAMPLE, 16'h4000);
        wait_for_results();
        write_register(tfcr_pkg::RegExpectedThrottle, 16'hFFFF);
        write_register(tfcr_pkg::RegSensorVirtual, 16'd1);
        send_item(KIND_REQUEST, 16'hFFFF);
        wait_for_results();
        write_register(tfcr_pkg::RegExpectedThrottle, 16'h0000);
        send_item(KIND_SAMPLE, 16'hFFFF);
        restore_defaults();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        int n;
        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request++;
        for (n = 0; n < 12; n++) begin
            send_item(n[0] ? KIND_REQUEST : KIND_SAMPLE, 16'($urandom_range(0, 65534)));
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int                         phase;
        int                         counted;
        bit                         paused;
        logic                       kind;
        logic [tfcr_pkg::DataW-1:0] sample;
        for (phase = 0; phase < 6; phase++) begin
            wait_for_results();
            set_idling(phase);
            load_random_setting();
            counted = 0;
            paused  = 1'b0;
            while (counted < PHASE_ITEMS) begin
                kind = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0: sample = tfcr_pkg::FailedSample;
                    1: sample = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFE;
                    2: sample = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                    default: sample = 16'($urandom_range(0, 65535));
                endcase
                counted++;
                send_item(kind, sample);
                // sender goes quiet until everything has come back
                if (!paused && counted >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    wait_for_results();
                end
            end
        end
    endtask

    initial begin : run_tests
        int waited;
        cfg_virtual   = 1'b0;
        cfg_expected  = '0;
        cfg_bandwidth = tfcr_pkg::RstFilterBandwidth;
        cfg_slope     = tfcr_pkg::RstTargetSlope;
        cfg_offset    = '0;
        cfg_step      = tfcr_pkg::RstRampStep;
        flt_level     = '0;
        ramp_ref      = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0);
        test_filter_extremes();
        test_ramp_extremes();
        test_virtual_mode();
        test_output_backpressure();
        test_random_traffic();

        i_in_valid <= 1'b0;
        waited = 0;
        while (awaited_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (awaited_outputs.size() != 0) begin
            report_mismatch("results never produced", 16'(awaited_outputs.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : run_limit
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
